### hdl/chd_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the chorus.
// Depends on nothing; chd_ram aside, the design files use it by scoped names.
`default_nettype none

package chd_pkg;

  // Sample and phase formats
  localparam int SAMPLE_W  = 24;
  localparam int PHASE_W   = 24;
  localparam int DEPTH_W   = 13;
  localparam int MIX_W     = 17;

  // Delay line depth default (power of two, 1024 to 65536)
  localparam int DELAY_DEPTH_DEF = 16384;

  // Sine table: full-cycle entries, stored as a quarter wave plus one end point
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int QTR        = SINE_DEPTH / 4;
  localparam int QTR_AW     = $clog2(QTR) + 1;

  // Mix constants: 65536 is unity, anything at or below 655 bypasses
  localparam logic [MIX_W-1:0] MIX_ONE      = 17'd65536;
  localparam logic [MIX_W-1:0] BYPASS_LIMIT = 17'd656;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_INC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX     = 2'd2;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  typedef logic [30:0] qtab_t [QTR+1];

  // sin of a quarter-turn fraction r (Q30), Taylor series to x^15, Q30 result
  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    x    = (r * HALF_PI_Q30) >> 30;
    sum  = x;
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      unique case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((n % 2) == 1) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return (sum > Q30_ONE) ? Q30_ONE : sum;
  endfunction

  // Quarter-wave table, entry j = sin(2*pi*j/SINE_DEPTH), j = 0 .. QTR
  function automatic qtab_t build_qtab();
    qtab_t       t;
    logic [63:0] r;
    logic [63:0] s;
    for (int j = 0; j <= QTR; j++) begin
      r    = 64'(j) << (32 - SINE_AW);
      s    = quarter_sine(r);
      t[j] = s[30:0];
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/chd_if.sv
// Channel interfaces of the chorus: sample input, sample output, register writes.
// Depends on chd_pkg for field widths.
`default_nettype none

interface chd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [chd_pkg::SAMPLE_W-1:0]  left_in;
  logic signed [chd_pkg::SAMPLE_W-1:0]  right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface chd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [chd_pkg::SAMPLE_W-1:0]  left_out;
  logic signed [chd_pkg::SAMPLE_W-1:0]  right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface chd_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [chd_pkg::CFG_IDX_W-1:0]         index;
  logic [chd_pkg::CFG_DATA_W-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/chd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module chd_ram #(
  parameter int Width = 24,
  parameter int Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/chd_sine.sv
// Registered sine lookup: full-cycle index folded onto a quarter-wave table, Q30.
// Depends on chd_pkg for the table builder and sizes.
`default_nettype none

module chd_sine (
  input  wire logic                           clk_i,
  input  wire logic [chd_pkg::SINE_AW-1:0]    k_i,
  output      logic signed [chd_pkg::MUL_A_W-1:0] sine_o
);

  localparam chd_pkg::qtab_t QTAB = chd_pkg::build_qtab();

  logic [1:0]                    quad;
  logic [chd_pkg::SINE_AW-3:0]   kq;
  logic [chd_pkg::QTR_AW-1:0]    j;
  logic [30:0]                   mag;
  logic signed [chd_pkg::MUL_A_W-1:0] val;

  // Quadrant fold: odd quadrants run backwards, upper half is negative
  always_comb begin
    quad = k_i[chd_pkg::SINE_AW-1 -: 2];
    kq   = k_i[chd_pkg::SINE_AW-3:0];
    if (quad[0]) begin
      j = chd_pkg::QTR_AW'(chd_pkg::QTR) - chd_pkg::QTR_AW'(kq);
    end else begin
      j = chd_pkg::QTR_AW'(kq);
    end
    mag = QTAB[j];
    val = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    sine_o <= val;
  end

endmodule

`default_nettype wire

### hdl/chd_mul.sv
// Shared signed multiplier with a registered product, reused for every multiply step.
// Depends on chd_pkg for operand widths.
`default_nettype none

module chd_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [chd_pkg::MUL_A_W-1:0]  a_i,
  input  wire logic signed [chd_pkg::MUL_B_W-1:0]  b_i,
  output      logic signed [chd_pkg::MUL_P_W-1:0]  p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

### hdl/stereo_chorus_delay.sv
// Top level of the stereo chorus: sequencer, LFO, delay lines and output register.
// Depends on chd_pkg, chd_if, chd_ram, chd_sine and chd_mul.
//
//   port    | dir | carries
//   smp_i   | in  | left_in, right_in      (valid/ready)
//   smp_o   | out | left_out, right_out    (valid/ready)
//   cfg_i   | in  | index, data            (valid/ready, always ready)
//
// An item's result enters the output register from the final step (a bypassed item goes
// there straight from acceptance); the next item is accepted only after that, so items
// do not overlap. The shared multiplier is used three times per channel, channels
// run one after the other.
// Reset clears the sequencer, write position, fill flag, LFO phase, config registers and
// output valid flag; delay lines need no clearing: reads past the fill point return zero.
// A result waiting on the output does not block the next item's acceptance; that item
// stalls in its final step until the output register frees.
`default_nettype none

module stereo_chorus_delay #(
  parameter int DELAY_DEPTH = chd_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  chd_in_if.sink     smp_i,
  chd_out_if.source  smp_o,
  chd_cfg_if.sink    cfg_i
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int PW = AW + 16;
  localparam int SW = chd_pkg::SAMPLE_W;
  localparam int PRW = chd_pkg::MUL_P_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LFO  = 4'd1;
  localparam logic [3:0] ST_MDEP = 4'd2;
  localparam logic [3:0] ST_POS  = 4'd3;
  localparam logic [3:0] ST_RD1  = 4'd4;
  localparam logic [3:0] ST_RD2  = 4'd5;
  localparam logic [3:0] ST_S2   = 4'd6;
  localparam logic [3:0] ST_MWET = 4'd7;
  localparam logic [3:0] ST_WET  = 4'd8;
  localparam logic [3:0] ST_MMIX = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;
  localparam logic [3:0] ST_WR   = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  localparam logic signed [PRW-1:0] SMAX = PRW'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [PRW-1:0] SMIN = -SMAX - PRW'(1);

  logic [3:0] state_q, state_d;
  logic       ch_q, ch_d;

  // Configuration registers
  logic [chd_pkg::PHASE_W-1:0] inc_q;
  logic [chd_pkg::DEPTH_W-1:0] depth_q;
  logic [chd_pkg::MIX_W-1:0]   mix_q;

  // LFO and delay line control
  logic [chd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [AW-1:0]               wp_q, wp_d;
  logic                        full_q, full_d;

  // Item working registers
  logic signed [SW-1:0]        in_l_q, in_r_q;
  logic [chd_pkg::MIX_W-1:0]   m_q;
  logic [AW-1:0]               i1_q, i2_q;
  logic [15:0]                 f_q;
  logic                        v1_q, v2_q;
  logic signed [SW-1:0]        s1_q, s2_q, wet_q;
  logic signed [SW-1:0]        res_l_q, res_r_q;

  // Output register
  logic                        ovalid_q;
  logic signed [SW-1:0]        oleft_q, oright_q;

  // Datapath wires
  logic [chd_pkg::SINE_AW-1:0]          k_sel;
  logic signed [chd_pkg::MUL_A_W-1:0]   sine;
  logic signed [chd_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [chd_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [PRW-1:0]                prod;
  logic [AW-1:0]                        raddr;
  logic [SW-1:0]                        rd_l, rd_r;
  logic signed [SW-1:0]                 rd_sel, in_sel;
  logic [47:0]                          dsum;
  logic [PW-1:0]                        pos;
  logic signed [SW:0]                   wdiff;
  logic signed [SW+1:0]                 mdiff;
  logic signed [PRW-1:0]                wsum, osum, oval;
  logic signed [SW-1:0]                 osat;
  logic                                 accept, bypass, out_free, ram_we;

  assign cfg_i.ready = 1'b1;
  assign smp_i.ready = (state_q == ST_IDLE);
  assign accept      = smp_i.valid && smp_i.ready;
  assign bypass      = (mix_q < chd_pkg::BYPASS_LIMIT);
  assign out_free    = !ovalid_q || smp_o.ready;

  assign smp_o.valid     = ovalid_q;
  assign smp_o.left_out  = oleft_q;
  assign smp_o.right_out = oright_q;

  // Sine index: left uses the phase, right a quarter turn later
  assign k_sel = phase_q[chd_pkg::PHASE_W-1 -: chd_pkg::SINE_AW]
               + (ch_q ? chd_pkg::SINE_AW'(chd_pkg::QTR) : '0);

  chd_sine u_sine (
    .clk_i  (clk_i),
    .k_i    (k_sel),
    .sine_o (sine)
  );

  chd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign ram_we = (state_q == ST_WR);
  assign raddr  = (state_q == ST_RD2) ? i2_q : i1_q;

  chd_ram #(.Width(SW), .Depth(DELAY_DEPTH)) u_line_l (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_l_q),
    .raddr_i (raddr),
    .rdata_o (rd_l)
  );

  chd_ram #(.Width(SW), .Depth(DELAY_DEPTH)) u_line_r (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_r_q),
    .raddr_i (raddr),
    .rdata_o (rd_r)
  );

  assign rd_sel = ch_q ? $signed(rd_r) : $signed(rd_l);
  assign in_sel = ch_q ? in_r_q : in_l_q;

  // Read position: write position minus delay, wrapped to the line
  assign dsum = ((48'(depth_q) * 48'd3) << 29) + (48'd100 << 30) + prod[47:0];
  assign pos  = {wp_q, 16'b0} - dsum[PW+13:14];

  // Interpolation and mix arithmetic
  assign wdiff = {s2_q[SW-1], s2_q} - {s1_q[SW-1], s1_q};
  assign mdiff = {wet_q[SW-1], wet_q, 1'b0} - {{2{in_sel[SW-1]}}, in_sel};
  assign wsum  = (PRW'(s1_q) <<< 16) + prod + PRW'(32768);
  assign osum  = (PRW'(in_sel) <<< 17) + prod + PRW'(65536);
  assign oval  = osum >>> 17;

  always_comb begin
    if (oval > SMAX) begin
      osat = SMAX[SW-1:0];
    end else if (oval < SMIN) begin
      osat = SMIN[SW-1:0];
    end else begin
      osat = oval[SW-1:0];
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MDEP: begin
        mul_a = sine;
        mul_b = chd_pkg::MUL_B_W'(depth_q);
      end
      ST_MWET: begin
        mul_a = chd_pkg::MUL_A_W'(wdiff);
        mul_b = chd_pkg::MUL_B_W'(f_q);
      end
      ST_MMIX: begin
        mul_a = chd_pkg::MUL_A_W'(mdiff);
        mul_b = chd_pkg::MUL_B_W'(m_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    phase_d = phase_q;
    wp_d    = wp_q;
    full_d  = full_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ch_d = 1'b0;
          if (bypass) begin
            state_d = ST_FIN;
          end else begin
            phase_d = phase_q + inc_q;
            state_d = ST_LFO;
          end
        end
      end
      ST_LFO:  state_d = ST_MDEP;
      ST_MDEP: state_d = ST_POS;
      ST_POS:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_S2;
      ST_S2:   state_d = ST_MWET;
      ST_MWET: state_d = ST_WET;
      ST_WET:  state_d = ST_MMIX;
      ST_MMIX: state_d = ST_OUT;
      ST_OUT: begin
        if (!ch_q) begin
          ch_d    = 1'b1;
          state_d = ST_LFO;
        end else begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        wp_d    = wp_q + AW'(1);
        if (wp_q == AW'(DELAY_DEPTH - 1)) begin
          full_d = 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ch_q     <= 1'b0;
      phase_q  <= '0;
      wp_q     <= '0;
      full_q   <= 1'b0;
      inc_q    <= '0;
      depth_q  <= '0;
      mix_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      phase_q <= phase_d;
      wp_q    <= wp_d;
      full_q  <= full_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          chd_pkg::REG_LFO_INC: inc_q   <= cfg_i.data[chd_pkg::PHASE_W-1:0];
          chd_pkg::REG_DEPTH:   depth_q <= cfg_i.data[chd_pkg::DEPTH_W-1:0];
          chd_pkg::REG_MIX:     mix_q   <= cfg_i.data[chd_pkg::MIX_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_FIN && out_free) begin
        ovalid_q <= 1'b1;
      end else if (smp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_l_q <= smp_i.left_in;
      in_r_q <= smp_i.right_in;
      m_q    <= (mix_q > chd_pkg::MIX_ONE) ? chd_pkg::MIX_ONE : mix_q;
      if (bypass) begin
        res_l_q <= smp_i.left_in;
        res_r_q <= smp_i.right_in;
      end
    end
    if (state_q == ST_POS) begin
      i1_q <= pos[PW-1:16];
      i2_q <= pos[PW-1:16] + AW'(1);
      f_q  <= pos[15:0];
    end
    if (state_q == ST_RD1) begin
      v1_q <= full_q || (i1_q < wp_q);
      v2_q <= full_q || (i2_q < wp_q);
    end
    if (state_q == ST_RD2) begin
      s1_q <= v1_q ? rd_sel : '0;
    end
    if (state_q == ST_S2) begin
      s2_q <= v2_q ? rd_sel : '0;
    end
    if (state_q == ST_WET) begin
      wet_q <= wsum[SW+15:16];
    end
    if (state_q == ST_OUT) begin
      if (ch_q) begin
        res_r_q <= osat;
      end else begin
        res_l_q <= osat;
      end
    end
    if (state_q == ST_FIN && out_free) begin
      oleft_q  <= res_l_q;
      oright_q <= res_r_q;
    end
  end

endmodule

`default_nettype wire

### tb/stereo_chorus_delay_tb.sv
// Self-checking bench for the stereo chorus: drives sample pairs and register writes,
// predicts each chorused pair with an internal fixed-point model and compares outputs.
// Depends on chd_pkg, the chd_if interfaces and the stereo_chorus_delay RTL.
`default_nettype none

module stereo_chorus_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chd_pkg::*;

  localparam int LINE_DEPTH = DELAY_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } pair_t;

  typedef struct packed {
    logic                  is_cfg;
    logic                  drain;     // hold off until every pair has come back
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    pair_t                 smp;
  } job_t;

  logic clk_i;
  logic rst_ni;

  chd_in_if  smp_if ();
  chd_out_if out_if ();
  chd_cfg_if cfg_if ();

  stereo_chorus_delay u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_if.sink),
    .smp_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Chorus model state
  logic signed [SAMPLE_W-1:0] line_l [LINE_DEPTH];
  logic signed [SAMPLE_W-1:0] line_r [LINE_DEPTH];
  logic [13:0]         wr_pos;
  logic [PHASE_W-1:0]  phase;
  logic [PHASE_W-1:0]  lfo_inc;
  logic [DEPTH_W-1:0]  depth;
  logic [MIX_W-1:0]    mix;
  longint              sine_tab [SINE_DEPTH];

  job_t  jobs [$];
  pair_t chorus_expected [$];
  int    mismatches;
  bit    timed_out;
  bit    stim_done;

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat_sample(longint v);
    longint hi;
    hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  // Taylor-series sine of a quarter-turn fraction, Q30 in and out
  function automatic longint qsine(longint unsigned r);
    longint unsigned x, acc, t;
    x = (r * 64'd1686629713) >> 30;
    acc = x;
    t = x;
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = (acc > t) ? acc - t : 0;
      else acc = acc + t;
    end
    return (acc > (64'd1 << 30)) ? (64'd1 << 30) : acc;
  endfunction

  function automatic longint interp_wet(ref logic signed [SAMPLE_W-1:0] ln [LINE_DEPTH],
                                        input longint lfo);
    longint dq30, span, pos, f, w;
    longint unsigned dq16;
    int i1, i2;
    dq30 = ((3 * longint'(depth)) <<< 29) + (longint'(100) <<< 30) + longint'(depth) * lfo;
    dq16 = longint'(unsigned'(dq30)) >> 14;
    span = longint'(LINE_DEPTH) << 16;
    pos = ((longint'(wr_pos) << 16) + span - longint'(dq16 % span)) % span;
    i1 = int'((pos >> 16) % LINE_DEPTH);
    i2 = (i1 + 1) % LINE_DEPTH;
    f = pos & 16'hFFFF;
    w = longint'(ln[i1]) * (65536 - f) + longint'(ln[i2]) * f;
    return round_shr(w, 16);
  endfunction

  // Return the chorused pair and advance the model, or return a bypassed pair unchanged
  function automatic pair_t chorus_step(pair_t din);
    pair_t  o;
    longint m, wl, wr, k, kc;
    m = (mix > 17'd65536) ? 65536 : longint'(mix);
    if (m * 100 < 65536) return din;
    phase = phase + lfo_inc;
    k = (longint'(phase) * SINE_DEPTH) >> PHASE_W;
    kc = (k + SINE_DEPTH / 4) % SINE_DEPTH;
    wl = interp_wet(line_l, sine_tab[k]);
    wr = interp_wet(line_r, sine_tab[kc]);
    line_l[wr_pos] = din.left;
    line_r[wr_pos] = din.right;
    wr_pos = wr_pos + 1;
    o.left  = SAMPLE_W'(sat_sample(round_shr(longint'(din.left) * (131072 - m)
                                             + 2 * wl * m, 17)));
    o.right = SAMPLE_W'(sat_sample(round_shr(longint'(din.right) * (131072 - m)
                                             + 2 * wr * m, 17)));
    return o;
  endfunction

  // Driver: takes one job at a time, waits out gaps and drain points
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
      smp_if.left_in <= '0;
      smp_if.right_in <= '0;
      cfg_if.valid <= 1'b0;
      cfg_if.index <= '0;
      cfg_if.data <= '0;
      gap_left <= 0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        chorus_expected.push_back(chorus_step({smp_if.left_in, smp_if.right_in}));
        smp_if.valid <= 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_LFO_INC: lfo_inc = cfg_if.data;
          REG_DEPTH:   depth = cfg_if.data[DEPTH_W-1:0];
          REG_MIX:     mix = cfg_if.data[MIX_W-1:0];
          default: ;
        endcase
        cfg_if.valid <= 1'b0;
      end
      if (!(smp_if.valid && !smp_if.ready) && !(cfg_if.valid && !cfg_if.ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (jobs.size() > 0) begin
          if (jobs[0].drain || jobs[0].is_cfg) begin
            // registers only move with nothing in flight
            if (chorus_expected.size() == 0 && !smp_if.valid && !cfg_if.valid) begin
              if (jobs[0].drain) begin
                void'(jobs.pop_front());
                gap_left <= 40;
              end else begin
                cfg_if.valid <= 1'b1;
                cfg_if.index <= jobs[0].index;
                cfg_if.data <= jobs[0].data;
                void'(jobs.pop_front());
                gap_left <= 2;
              end
            end
          end else if (!smp_if.valid) begin
            smp_if.valid <= 1'b1;
            smp_if.left_in <= jobs[0].smp.left;
            smp_if.right_in <= jobs[0].smp.right;
            void'(jobs.pop_front());
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                      : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
          end
        end
      end
    end
  end

  // Monitor: random backpressure and field comparison
  int stall_left;
  int idle_cycles;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (chorus_expected.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected pair L=%0d R=%0d", out_if.left_out, out_if.right_out);
        end else begin
          pair_t e;
          e = chorus_expected.pop_front();
          if (e.left !== out_if.left_out || e.right !== out_if.right_out) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("pair mismatch: expected L=%0d R=%0d got L=%0d R=%0d",
                       e.left, e.right, out_if.left_out, out_if.right_out);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
      if ((smp_if.valid && smp_if.ready) || (out_if.valid && out_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
  end

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    job_t j;
    j = '0;
    j.is_cfg = 1'b1;
    j.index = idx;
    j.data = val;
    jobs.push_back(j);
  endtask

  task automatic add_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
    job_t j;
    j = '0;
    j.smp.left = l;
    j.smp.right = r;
    jobs.push_back(j);
  endtask

  task automatic add_drain();
    job_t j;
    j = '0;
    j.drain = 1'b1;
    jobs.push_back(j);
  endtask

  function automatic logic [SAMPLE_W-1:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return SAMPLE_W'($urandom_range(0, 255)) - 24'd128;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int pick;
    logic [MIX_W-1:0] mix_pick;
    mismatches = 0;
    timed_out = 1'b0;
    stim_done = 1'b0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_l[i] = '0;
      line_r[i] = '0;
    end
    // full-cycle sine by quadrant folding
    for (int k = 0; k < SINE_DEPTH; k++) begin
      longint unsigned u, q, r;
      u = (longint'(k) << 32) / SINE_DEPTH;
      q = (u >> 30) & 3;
      r = u & ((64'd1 << 30) - 1);
      if (q[0]) r = (64'd1 << 30) - r;
      sine_tab[k] = q[1] ? -qsine(r) : qsine(r);
    end
    wr_pos = '0;
    phase = '0;
    lfo_inc = '0;
    depth = '0;
    mix = '0;
    out_if.ready = 1'b0;
    smp_if.valid = 1'b0;
    smp_if.left_in = '0;
    smp_if.right_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;

    // Directed: bypass at reset, threshold edge, full mix, extremes
    add_pair(24'h7FFFFF, 24'h800000);
    add_pair(24'h000001, 24'hFFFFFF);
    add_cfg(REG_MIX, 24'd655);
    add_pair(24'h123456, 24'h876543);
    add_drain();
    add_cfg(REG_MIX, 24'd656);
    add_cfg(REG_LFO_INC, 24'hFFFFFF);
    add_cfg(REG_DEPTH, 24'd6500);
    add_pair(24'h7FFFFF, 24'h7FFFFF);
    add_pair(24'h800000, 24'h800000);
    add_drain();
    add_cfg(REG_MIX, 24'h01FFFF);
    add_cfg(REG_DEPTH, 24'd0);
    add_cfg(REG_LFO_INC, 24'd0);
    for (int i = 0; i < 6; i++) add_pair(24'h7FFFFF, 24'h800000);
    add_drain();
    add_cfg(REG_MIX, 24'd65536);
    add_cfg(REG_DEPTH, 24'd8191);
    add_cfg(REG_LFO_INC, 24'd349525);
    for (int i = 0; i < 8; i++) add_pair(i[0] ? 24'h800000 : 24'h7FFFFF, rnd_sample());

    // Random phases; short delays make recent samples show up in the wet path
    for (int ph = 0; ph < 16; ph++) begin
      add_drain();
      pick = $urandom_range(0, 9);
      mix_pick = (pick == 0) ? MIX_W'($urandom_range(0, 655))
               : (pick == 1) ? 17'h1FFFF
               : (pick == 2) ? 17'd65536 : MIX_W'($urandom_range(656, 65536));
      add_cfg(REG_MIX, 24'(mix_pick));
      add_cfg(REG_DEPTH, ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 8191))
                                                     : 24'($urandom_range(0, 4)));
      add_cfg(REG_LFO_INC, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(0, 70000)));
      for (int i = 0; i < 50; i++) add_pair(rnd_sample(), rnd_sample());
    end

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out && (jobs.size() > 0 || smp_if.valid || cfg_if.valid
                          || chorus_expected.size() > 0))
      @(posedge clk_i);
    if (!timed_out) repeat (50) @(posedge clk_i);
    if (timed_out || mismatches > 0 || chorus_expected.size() > 0) begin
      $display("Verification failed");
    end else begin
      $display("Verification passed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hdl/chd_pkg.sv
hdl/chd_if.sv
hdl/chd_ram.sv
hdl/chd_sine.sv
hdl/chd_mul.sv
hdl/stereo_chorus_delay.sv
tb/stereo_chorus_delay_tb.sv
